/* hdl/iirdf_pkg.sv */
package iirdf_pkg;

   localparam int DEFAULT_ORDER       = 4;
   localparam int DEFAULT_SAMPLE_BITS = 16;
   localparam int MAX_ORDER           = 4;

   localparam int COEF_W    = 32;
   localparam int CSR_W     = 2 * COEF_W;
   localparam int CSR_IDX_W = 3;
   localparam int ACC_FRAC  = 28;
   localparam int HIST_FRAC = 16;
   localparam int HIST_W    = 32;
   localparam int FB_W      = 2 * COEF_W - HIST_FRAC;

   localparam logic [CSR_IDX_W-1:0] CSR_FWD_COEF_0_1  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_COEF_2_3  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_COEF_4    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COEF_1_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COEF_3_4 = 3'd4;

   typedef struct packed {
      logic load;
      logic advance;
   } cell_ctrl_type;

endpackage

/* hdl/iirdf_cell.sv */
module iirdf_cell
   import iirdf_pkg::*;
#(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   parameter int PROD_W      = SAMPLE_BITS + COEF_W,
   parameter int ACC_W       = PROD_W + 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctrl_type                 ctrl,
   input  logic signed [SAMPLE_BITS-1:0] x_in,
   output logic signed [SAMPLE_BITS-1:0] x_out,
   input  logic signed [HIST_W-1:0]      h_in,
   output logic signed [HIST_W-1:0]      h_out,
   input  logic signed [COEF_W-1:0]      fwd_coef,
   input  logic signed [COEF_W-1:0]      back_coef,
   input  logic signed [ACC_W-1:0]       sum_in,
   output logic signed [ACC_W-1:0]       sum_out
);

   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [HIST_W-1:0]      h_ff;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [PROD_W-1:0]      prod_in;
   logic signed [2*COEF_W-1:0]    fb_prod;
   logic signed [ACC_W-1:0]       prod_ext;
   logic signed [ACC_W-1:0]       fb_ext;

   assign prod_in  = fwd_coef * x_ff;
   assign fb_prod  = back_coef * h_ff;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign fb_ext   = {{(ACC_W-FB_W){fb_prod[2*COEF_W-1]}}, fb_prod[2*COEF_W-1:HIST_FRAC]};

   assign sum_out = prod_ext + fb_ext + sum_in;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         h_ff <= '0;
      end else begin
         if (ctrl.load) begin
            x_ff <= x_in;
         end
         if (ctrl.advance) begin
            h_ff <= h_in;
         end
      end
   end

   assign x_out = x_ff;
   assign h_out = h_ff;

endmodule

/* hdl/iir_direct_form_one_filter.sv */
// Fourth-order recursive filter, direct form I, built as a chain of history cells.
// Input channel req_*: one signed sample per transaction (valid/ready).
// Result channel rsp_*: the filtered sample, rounded and saturated to SAMPLE_BITS,
// and a clipped flag that marks saturation.
// Configuration port csr_*: write-only, coefficients signed Q4.28 packed two to a
// register (forward coefficient 4 alone); write only while no transaction is in flight.
// An accepted sample is registered in the input stage and then in the output register.
// Throughput: one sample per cycle while the receiver does not stall. The rate is set by
// the feedback loop, which runs combinationally from each cell's output history word
// through its coefficient multiplier and the partial-sum chain to the new history word.
// The input stage holds the forward products; the cells hold the input and output
// history and shift it one place per transaction.
// Reset clears the coefficients, both histories and both valid flags; no clearing
// pass is needed.
// When the receiver stalls, the output register holds its result, one more sample
// waits in the input stage, and req_ready then drops until rsp_ready returns.
module iir_direct_form_one_filter
   import iirdf_pkg::*;
#(
   parameter int ORDER       = DEFAULT_ORDER,
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_clipped,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int ACC_W  = ((PROD_W > FB_W) ? PROD_W : FB_W) + 4;

   localparam logic signed [ACC_W-1:0] ONE      = {{(ACC_W-1){1'b0}}, 1'b1};
   localparam logic signed [ACC_W-1:0] ROUND_Y  = ONE << (ACC_FRAC - 1);
   localparam logic signed [ACC_W-1:0] ROUND_H  = ONE << (ACC_FRAC - HIST_FRAC - 1);
   localparam logic signed [ACC_W-1:0] SMAX =
      {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMIN =
      {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HMAX =
      {{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] HMIN =
      {{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};

   logic signed [COEF_W-1:0] fwd_coef_ff  [0:MAX_ORDER];
   logic signed [COEF_W-1:0] back_coef_ff [1:MAX_ORDER];

   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   logic signed [PROD_W-1:0]      prod0_ff;
   logic signed [PROD_W-1:0]      prod0_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff;
   logic signed [SAMPLE_BITS-1:0] sample_out_in;
   logic                          clipped_ff;
   logic                          clipped_in;

   logic          advance;
   logic          fire;
   logic          load;
   cell_ctrl_type cell_ctrl;

   logic signed [ACC_W-1:0]       chain_sum [1:ORDER+1];
   logic signed [SAMPLE_BITS-1:0] x_chain   [0:ORDER];
   logic signed [HIST_W-1:0]      h_chain   [0:ORDER];
   logic signed [ACC_W-1:0]       acc;
   logic signed [ACC_W-1:0]       y_shift;
   logic signed [ACC_W-1:0]       h_shift;
   logic signed [HIST_W-1:0]      hist;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_ORDER; i++) begin
            fwd_coef_ff[i] <= '0;
         end
         for (int i = 1; i <= MAX_ORDER; i++) begin
            back_coef_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FWD_COEF_0_1: begin
               fwd_coef_ff[0] <= csr_wdata[COEF_W-1:0];
               fwd_coef_ff[1] <= csr_wdata[CSR_W-1:COEF_W];
            end
            CSR_FWD_COEF_2_3: begin
               fwd_coef_ff[2] <= csr_wdata[COEF_W-1:0];
               fwd_coef_ff[3] <= csr_wdata[CSR_W-1:COEF_W];
            end
            CSR_FWD_COEF_4: begin
               fwd_coef_ff[4] <= csr_wdata[COEF_W-1:0];
            end
            CSR_BACK_COEF_1_2: begin
               back_coef_ff[1] <= csr_wdata[COEF_W-1:0];
               back_coef_ff[2] <= csr_wdata[CSR_W-1:COEF_W];
            end
            CSR_BACK_COEF_3_4: begin
               back_coef_ff[3] <= csr_wdata[COEF_W-1:0];
               back_coef_ff[4] <= csr_wdata[CSR_W-1:COEF_W];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = stage_valid_ff && advance;
   assign req_ready = !stage_valid_ff || advance;
   assign load      = req_valid && req_ready;

   assign cell_ctrl.load    = load;
   assign cell_ctrl.advance = fire;

   assign stage_valid_in = load || (stage_valid_ff && !advance);
   assign out_valid_in   = advance ? stage_valid_ff : out_valid_ff;
   assign prod0_in       = fwd_coef_ff[0] * req_sample_in;

   assign chain_sum[ORDER+1] = '0;
   assign x_chain[0]         = req_sample_in;
   assign h_chain[0]         = hist;

   for (genvar k = 1; k <= ORDER; k++) begin : g_cell
      iirdf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .PROD_W      (PROD_W),
         .ACC_W       (ACC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .x_in      (x_chain[k-1]),
         .x_out     (x_chain[k]),
         .h_in      (h_chain[k-1]),
         .h_out     (h_chain[k]),
         .fwd_coef  (fwd_coef_ff[k]),
         .back_coef (back_coef_ff[k]),
         .sum_in    (chain_sum[k+1]),
         .sum_out   (chain_sum[k])
      );
   end

   assign acc     = {{(ACC_W-PROD_W){prod0_ff[PROD_W-1]}}, prod0_ff} + chain_sum[1];
   assign y_shift = (acc + ROUND_Y) >>> ACC_FRAC;
   assign h_shift = (acc + ROUND_H) >>> (ACC_FRAC - HIST_FRAC);

   always_comb begin
      if (h_shift > HMAX) begin
         hist = HMAX[HIST_W-1:0];
      end else if (h_shift < HMIN) begin
         hist = HMIN[HIST_W-1:0];
      end else begin
         hist = h_shift[HIST_W-1:0];
      end
   end

   always_comb begin
      if (y_shift > SMAX) begin
         sample_out_in = SMAX[SAMPLE_BITS-1:0];
         clipped_in    = 1'b1;
      end else if (y_shift < SMIN) begin
         sample_out_in = SMIN[SAMPLE_BITS-1:0];
         clipped_in    = 1'b1;
      end else begin
         sample_out_in = y_shift[SAMPLE_BITS-1:0];
         clipped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod0_ff <= prod0_in;
      end
      if (fire) begin
         sample_out_ff <= sample_out_in;
         clipped_ff    <= clipped_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_clipped    = clipped_ff;

endmodule

/* hdl/iirdf_checker.sv */
module iirdf_checker
   import iirdf_pkg::*;
#(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_clipped
);

   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output register is empty");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> (rsp_sample_out == SMAX) || (rsp_sample_out == SMIN))
      else $error("clipped result not at a rail");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample_in))
      else $error("waiting input transaction changed");

endmodule

bind iir_direct_form_one_filter iirdf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_iirdf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_sample_in  (req_sample_in),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_clipped    (rsp_clipped)
);
